@@ sv/wsle_pkg.sv @@
// Package for the word segment LPC extractor.
// Holds job types, register indexes, reset values and shared helpers.
// No dependencies.
package wsle_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LIM  = 2'd3;

    localparam logic [15:0] ALPHA_RST    = 16'd1311;
    localparam logic [14:0] MAG_THR_RST  = 15'd200;
    localparam logic [23:0] TIME_THR_RST = 24'd2000;
    localparam logic [7:0]  WORD_LIM_RST = 8'd15;

    localparam logic [1:0] JOB_START = 2'd0;
    localparam logic [1:0] JOB_ACC   = 2'd1;
    localparam logic [1:0] JOB_SOLVE = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_FRAC      = 28;
    localparam int DIV_STEPS   = 60;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic [23:0]        length;
        logic [7:0]         number;
        logic               final_word;
    } t_job;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

endpackage

@@ sv/wsle_ifs.sv @@
// Sample and result channel interfaces for the word segment LPC extractor.
// Depends on nothing.
interface wsle_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wsle_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef_one;
    logic signed [31:0] coef_two;
    logic signed [31:0] coef_three;
    logic [23:0]        word_length;
    logic [7:0]         word_number;
    logic               final_word;
    logic               singular;
    modport source (output valid, output coef_one, output coef_two, output coef_three,
                    output word_length, output word_number, output final_word,
                    output singular, input ready);
    modport sink   (input valid, input coef_one, input coef_two, input coef_three,
                    input word_length, input word_number, input final_word,
                    input singular, output ready);
endinterface

@@ sv/wsle_queue.sv @@
// Short job queue between the front and back parts.
// Depends on wsle_pkg for its depth.
module wsle_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_valid
);
    import wsle_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

@@ sv/wsle_front.sv @@
// Front part: takes samples, tracks the magnitude average, word state and history,
// and issues start, accumulate and solve jobs. Depends on wsle_pkg and wsle_ifs.
module wsle_front #(
    parameter int ORDER = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wsle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wsle_sample_if.sink                    i_sample,
    output wsle_pkg::t_job                 o_job,
    output logic [ORDER*16-1:0]            o_hist,
    output logic                           o_push,
    input  logic                           i_full
);
    import wsle_pkg::*;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_DEC  = 1'b1;

    logic               r_state;
    logic [15:0]        r_alpha;
    logic [14:0]        r_mthr;
    logic [23:0]        r_tthr;
    logic [7:0]         r_wlim;
    logic [31:0]        r_avg;
    logic               r_active;
    logic [23:0]        r_len;
    logic [7:0]         r_wd;
    logic               r_halted;
    logic signed [15:0] r_hist [ORDER];
    logic signed [15:0] r_samp;
    logic [31:0]        r_pa;
    logic [48:0]        r_pb;

    logic [15:0] smag;
    logic [49:0] sum;
    logic [31:0] avg_new;
    logic        hot;
    logic [23:0] len_inc;
    logic [7:0]  wd_inc;
    logic        is_final;
    logic        need;
    logic        commit;
    logic        take;

    assign smag     = i_sample.sample[15] ? 16'(-i_sample.sample) : 16'(i_sample.sample);
    assign sum      = {2'b0, r_pa, 16'b0} + {1'b0, r_pb};
    assign avg_new  = sum[47:16];
    assign hot      = avg_new >= {1'b0, r_mthr, 16'b0};
    assign len_inc  = (r_len != 24'hFFFFFF) ? r_len + 24'd1 : r_len;
    assign wd_inc   = r_wd + 8'd1;
    assign is_final = (wd_inc == r_wlim);
    assign need     = hot || (r_active && (len_inc > r_tthr));
    assign commit   = (r_state == F_DEC) && (!need || !i_full);
    assign o_push   = (r_state == F_DEC) && need && !i_full;
    assign take     = i_sample.valid && i_sample.ready;

    assign i_sample.ready = (r_state == F_IDLE);

    always_comb begin
        o_job.kind       = !r_active ? JOB_START : (hot ? JOB_ACC : JOB_SOLVE);
        o_job.sample     = r_samp;
        o_job.length     = len_inc;
        o_job.number     = r_wd;
        o_job.final_word = is_final;
        for (int g = 0; g < ORDER; g++) begin
            o_hist[g*16 +: 16] = r_hist[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_samp <= i_sample.sample;
            r_pa   <= smag * r_alpha;
            r_pb   <= r_avg * (17'h10000 - {1'b0, r_alpha});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_alpha  <= ALPHA_RST;
            r_mthr   <= MAG_THR_RST;
            r_tthr   <= TIME_THR_RST;
            r_wlim   <= WORD_LIM_RST;
            r_avg    <= '0;
            r_active <= 1'b0;
            r_len    <= '0;
            r_wd     <= '0;
            r_halted <= 1'b0;
            for (int g = 0; g < ORDER; g++) begin
                r_hist[g] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ALPHA:    r_alpha <= i_cfg_data[15:0];
                    CFG_MAG_THR:  r_mthr  <= i_cfg_data[14:0];
                    CFG_TIME_THR: r_tthr  <= i_cfg_data[23:0];
                    CFG_WORD_LIM: r_wlim  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                F_IDLE: begin
                    if (take && !r_halted) begin
                        r_state <= F_DEC;
                    end
                end
                F_DEC: begin
                    if (commit) begin
                        r_state <= F_IDLE;
                        r_avg   <= avg_new;
                        if (!r_active) begin
                            if (hot) begin
                                r_active <= 1'b1;
                                r_len    <= '0;
                            end
                        end else begin
                            r_len <= len_inc;
                            if (!hot) begin
                                r_active <= 1'b0;
                                if (len_inc > r_tthr) begin
                                    r_wd <= wd_inc;
                                    if (is_final) begin
                                        r_halted <= 1'b1;
                                    end
                                end
                            end
                        end
                        for (int g = ORDER - 1; g > 0; g--) begin
                            r_hist[g] <= r_hist[g-1];
                        end
                        r_hist[0] <= r_samp;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

@@ sv/wsle_back.sv @@
// Back part: correlation accumulation and the Gauss-Jordan solve, with the
// result register. Depends on wsle_pkg and wsle_ifs.
module wsle_back #(
    parameter int ORDER = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsle_pkg::t_job      i_job,
    input  logic [ORDER*16-1:0] i_hist,
    input  logic                i_valid,
    output logic                o_pop,
    wsle_result_if.source       o_result
);
    import wsle_pkg::*;

    localparam int JW = $clog2(ORDER + 1);
    localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int CW = $clog2(DIV_STEPS);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_AMUL  = 4'd1;
    localparam logic [3:0] B_AADD  = 4'd2;
    localparam logic [3:0] B_MAX   = 4'd3;
    localparam logic [3:0] B_NORM0 = 4'd4;
    localparam logic [3:0] B_NORM  = 4'd5;
    localparam logic [3:0] B_SCALE = 4'd6;
    localparam logic [3:0] B_PIV   = 4'd7;
    localparam logic [3:0] B_DLOAD = 4'd8;
    localparam logic [3:0] B_DIV   = 4'd9;
    localparam logic [3:0] B_DWR   = 4'd10;
    localparam logic [3:0] B_ROW   = 4'd11;
    localparam logic [3:0] B_EMUL  = 4'd12;
    localparam logic [3:0] B_EUPD  = 4'd13;
    localparam logic [3:0] B_OUT   = 4'd14;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};
    localparam logic [63:0] LIM_HI = 64'd1 << 30;
    localparam logic [63:0] LIM_LO = 64'd1 << 29;
    localparam logic [63:0] BIAS   = (64'd1 << Q_FRAC) - 64'd1;

    logic [3:0]         r_state;
    logic signed [63:0] r_acc [ORDER][ORDER+1];
    logic signed [31:0] r_w   [ORDER][ORDER+1];
    logic signed [15:0] r_hist [ORDER];
    logic signed [15:0] r_cur;
    logic               r_first;
    logic [JW-1:0]      r_i;
    logic [JW-1:0]      r_j;
    logic [JW-1:0]      r_k;
    logic signed [31:0] r_prod32;
    logic signed [63:0] r_prod64;
    logic [63:0]        r_big;
    logic [63:0]        r_tmp;
    logic               r_right;
    logic [5:0]         r_sh;
    logic signed [31:0] r_piv;
    logic signed [31:0] r_t;
    logic [59:0]        r_dq;
    logic [31:0]        r_rem;
    logic               r_neg;
    logic [CW-1:0]      r_cnt;
    logic               r_sing;
    logic [23:0]        r_len;
    logic [7:0]         r_num;
    logic               r_final;
    logic               r_out_valid;
    logic signed [31:0] r_coef [3];
    logic [23:0]        r_out_len;
    logic [7:0]         r_out_num;
    logic               r_out_final;
    logic               r_out_sing;

    logic [IW-1:0]      ii;
    logic [IW-1:0]      kk;
    logic               last_ent;
    logic signed [15:0] opb;
    logic signed [63:0] a64;
    logic signed [63:0] p64;
    logic signed [63:0] s64;
    logic               ovf;
    logic [63:0]        mcur;
    logic [63:0]        shv;
    logic [31:0]        den;
    logic [31:0]        vmag;
    logic [32:0]        trial;
    logic signed [31:0] qdiv;
    logic signed [63:0] pb;
    logic signed [36:0] diff;
    logic signed [31:0] upd;
    logic               out_free;

    assign ii       = r_i[IW-1:0];
    assign kk       = r_k[IW-1:0];
    assign last_ent = (r_i == JW'(ORDER - 1)) && (r_j == JW'(ORDER));
    assign o_pop    = (r_state == B_IDLE) && i_valid;
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        opb   = (r_j == JW'(ORDER)) ? r_cur : r_hist[r_j[IW-1:0]];
        a64   = r_first ? 64'sd0 : r_acc[ii][r_j];
        p64   = 64'(r_prod32);
        s64   = a64 + p64;
        ovf   = (a64[63] == p64[63]) && (s64[63] != a64[63]);
        mcur  = mag64(r_acc[ii][r_j]);
        shv   = r_right ? (mcur >> r_sh) : (mcur << r_sh);
        den   = r_piv[31] ? (32'd0 - 32'(r_piv)) : 32'(r_piv);
        vmag  = r_w[kk][r_j][31] ? (32'd0 - 32'(r_w[kk][r_j])) : 32'(r_w[kk][r_j]);
        trial = {r_rem, r_dq[59]};
        if (!r_neg) begin
            qdiv = (|r_dq[59:31]) ? S32_MAX : 32'(r_dq[31:0]);
        end else if ((|r_dq[59:32]) || (r_dq[31] && (|r_dq[30:0]))) begin
            qdiv = S32_MIN;
        end else begin
            qdiv = 32'(32'd0 - r_dq[31:0]);
        end
        pb   = (r_prod64 + (r_prod64[63] ? 64'(BIAS) : 64'sd0)) >>> Q_FRAC;
        diff = 37'(r_w[ii][r_j]) - 37'($signed(pb[35:0]));
        if (!diff[36] && (|diff[35:31])) begin
            upd = S32_MAX;
        end else if (diff[36] && !(&diff[35:31])) begin
            upd = S32_MIN;
        end else begin
            upd = diff[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    r_cur   <= i_job.sample;
                    r_first <= (i_job.kind == JOB_START);
                    r_len   <= i_job.length;
                    r_num   <= i_job.number;
                    r_final <= i_job.final_word;
                    r_big   <= '0;
                    for (int g = 0; g < ORDER; g++) begin
                        r_hist[g] <= i_hist[g*16 +: 16];
                    end
                end
            end
            B_AMUL: r_prod32 <= r_hist[ii] * opb;
            B_AADD: r_acc[ii][r_j] <= ovf ? (a64[63] ? S64_MIN : S64_MAX) : s64;
            B_MAX: begin
                if (mcur > r_big) begin
                    r_big <= mcur;
                end
            end
            B_NORM0: begin
                r_tmp   <= r_big;
                r_right <= (r_big >= LIM_HI);
                r_sh    <= '0;
            end
            B_NORM: begin
                if (r_right && (r_tmp >= LIM_HI)) begin
                    r_tmp <= r_tmp >> 1;
                    r_sh  <= r_sh + 6'd1;
                end else if (!r_right && (r_tmp < LIM_LO)) begin
                    r_tmp <= r_tmp << 1;
                    r_sh  <= r_sh + 6'd1;
                end
            end
            B_SCALE: begin
                r_w[ii][r_j] <= r_acc[ii][r_j][63] ? 32'(32'd0 - shv[31:0]) : 32'(shv[31:0]);
            end
            B_PIV: r_piv <= r_w[kk][kk];
            B_DLOAD: begin
                r_dq  <= {vmag, 28'b0};
                r_rem <= '0;
                r_neg <= r_w[kk][r_j][31] ^ r_piv[31];
                r_cnt <= '0;
            end
            B_DIV: begin
                if (trial >= {1'b0, den}) begin
                    r_rem <= 32'(trial - {1'b0, den});
                    r_dq  <= {r_dq[58:0], 1'b1};
                end else begin
                    r_rem <= trial[31:0];
                    r_dq  <= {r_dq[58:0], 1'b0};
                end
                r_cnt <= r_cnt + CW'(1);
            end
            B_DWR: r_w[kk][r_j] <= qdiv;
            B_ROW: r_t <= r_w[ii][kk];
            B_EMUL: r_prod64 <= r_w[kk][r_j] * r_t;
            B_EUPD: r_w[ii][r_j] <= upd;
            default: ;
        endcase
        if (r_state == B_OUT && out_free) begin
            for (int c = 0; c < 3; c++) begin
                r_coef[c] <= (c < ORDER && !r_sing) ? r_w[c % ORDER][ORDER] : 32'sd0;
            end
            r_out_len   <= r_len;
            r_out_num   <= r_num;
            r_out_final <= r_final;
            r_out_sing  <= r_sing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_sing      <= 1'b0;
        end else begin
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_sing  <= 1'b0;
                        r_state <= (i_job.kind == JOB_SOLVE) ? B_MAX : B_AMUL;
                    end
                end
                B_AMUL: r_state <= B_AADD;
                B_AADD, B_MAX, B_SCALE: begin
                    if (r_j == JW'(ORDER)) begin
                        r_j <= '0;
                        r_i <= r_i + JW'(1);
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                    if (r_state == B_AADD) begin
                        r_state <= last_ent ? B_IDLE : B_AMUL;
                    end else if (last_ent) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= (r_state == B_MAX) ? B_NORM0 : B_PIV;
                    end
                end
                B_NORM0: begin
                    if (r_big == '0) begin
                        r_sing  <= 1'b1;
                        r_state <= B_OUT;
                    end else begin
                        r_state <= B_NORM;
                    end
                end
                B_NORM: begin
                    if ((r_right && (r_tmp < LIM_HI)) || (!r_right && (r_tmp >= LIM_LO))) begin
                        r_state <= B_SCALE;
                    end
                end
                B_PIV: begin
                    if (r_w[kk][kk] == 32'sd0) begin
                        r_sing  <= 1'b1;
                        r_state <= B_OUT;
                    end else begin
                        r_j     <= '0;
                        r_state <= B_DLOAD;
                    end
                end
                B_DLOAD: r_state <= B_DIV;
                B_DIV: begin
                    if (r_cnt == CW'(DIV_STEPS - 1)) begin
                        r_state <= B_DWR;
                    end
                end
                B_DWR: begin
                    if (r_j == JW'(ORDER)) begin
                        r_i     <= '0;
                        r_state <= B_ROW;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= B_DLOAD;
                    end
                end
                B_ROW: begin
                    if (r_i == JW'(ORDER)) begin
                        if (r_k == JW'(ORDER - 1)) begin
                            r_state <= B_OUT;
                        end else begin
                            r_k     <= r_k + JW'(1);
                            r_state <= B_PIV;
                        end
                    end else if (r_i == r_k) begin
                        r_i <= r_i + JW'(1);
                    end else begin
                        r_j     <= '0;
                        r_state <= B_EMUL;
                    end
                end
                B_EMUL: r_state <= B_EUPD;
                B_EUPD: begin
                    if (r_j == JW'(ORDER)) begin
                        r_i     <= r_i + JW'(1);
                        r_state <= B_ROW;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= B_EMUL;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.coef_one    = r_coef[0];
    assign o_result.coef_two    = r_coef[1];
    assign o_result.coef_three  = r_coef[2];
    assign o_result.word_length = r_out_len;
    assign o_result.word_number = r_out_num;
    assign o_result.final_word  = r_out_final;
    assign o_result.singular    = r_out_sing;
endmodule

@@ sv/word_segment_lpc_extractor.sv @@
// Top level of the word segment LPC extractor: front, job queue and back.
// Depends on wsle_pkg, wsle_ifs, wsle_front, wsle_queue and wsle_back.
//
//   channel    dir  handshake        payload
//   i_sample   in   valid / ready    sample (s16)
//   o_result   out  valid / ready    coef_one..three, word_length, word_number,
//                                    final_word, singular
//   i_cfg_*    in   write enable     index 0..3, data 24 bits
//
// The front takes a sample in a multiply stage and decides on it in a decide stage. It takes
// no new sample until the decision commits, which waits while a job is due and the queue is full.
// Each start or accumulate job runs the back's multiply and add steps over every entry; a
// reported word adds a Gauss-Jordan solve that uses the one-bit-per-cycle divider.
// A two-job queue lets the front keep taking samples while the back works.
// Reset is synchronous and needs no clearing pass; the result register holds until taken.
module word_segment_lpc_extractor #(
    parameter int ORDER = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wsle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wsle_sample_if.sink                    i_sample,
    wsle_result_if.source                  o_result
);
    import wsle_pkg::*;

    localparam int QW = $bits(t_job) + ORDER * 16;

    t_job                f_job;
    logic [ORDER*16-1:0] f_hist;
    logic                f_push;
    logic                q_full;
    logic [QW-1:0]       q_data;
    logic                q_valid;
    logic                b_pop;
    t_job                b_job;
    logic [ORDER*16-1:0] b_hist;

    assign b_job  = t_job'(q_data[$bits(t_job)-1:0]);
    assign b_hist = q_data[QW-1:$bits(t_job)];

    wsle_front #(.ORDER(ORDER)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .o_job      (f_job),
        .o_hist     (f_hist),
        .o_push     (f_push),
        .i_full     (q_full)
    );

    wsle_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_hist, f_job}),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_data  (q_data),
        .o_valid (q_valid)
    );

    wsle_back #(.ORDER(ORDER)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (b_job),
        .i_hist   (b_hist),
        .i_valid  (q_valid),
        .o_pop    (b_pop),
        .o_result (o_result)
    );
endmodule
